[sv/ffca_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes of the first-fit cell allocator.
package ffca_pkg;

    localparam int OWNER_W  = 16;
    localparam int CFG_W    = 8;
    localparam int OP_W     = 2;
    localparam int LEN_W    = 8;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE = 2'd1;

    localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ERASED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DEFRAG  = 3'd4;

    localparam logic [CFG_W-1:0]   CFG_RESET  = 8'd128;
    localparam logic [OWNER_W-1:0] HANDLE_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_ERASE,
        S_PACK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic shift;
        logic pack;
    } t_cell_ctl;

endpackage

[sv/first_fit_cell_allocator_core.sv]
`timescale 1ns / 1ps
// Top level: first-fit allocator over a chain of owner cells.
//
//  channel  | handshake          | words
//  ---------+--------------------+----------------------------------------
//  request  | i_valid / o_ready  | i_op, i_block_length, i_handle_arg
//  response | o_valid / i_ready  | o_status, o_handle_out
//  config   | i_cfg_we           | i_cfg_wdata
//
// A successful allocate runs a scan rotation, then a fill rotation; a null allocate ends
// after the scan, or skips it for a zero length or an exhausted handle counter; erase runs
// one rotation; defragment runs compaction steps in place of a rotation.
// The ring of cells rotates one position per cycle past a single head unit.
// Reset clears every cell at once; no clearing sweep is needed.
// One request is in flight; a new one is taken while the last response waits.
module first_fit_cell_allocator_core
    import ffca_pkg::*;
#(
    parameter int CELLS = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [LEN_W-1:0]    i_block_length,
    input  logic [OWNER_W-1:0]  i_handle_arg,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [OWNER_W-1:0]  o_handle_out,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata
);

    localparam int IW = $clog2(CELLS);
    localparam int NW = IW + 1;
    localparam int CW = IW + 2;
    localparam logic [CW-1:0] PASS_END = CW'(CELLS - 1);
    localparam logic [CW-1:0] PACK_END = CW'(2 * CELLS - 1);

    t_state r_state, n_state;
    t_cell_ctl w_ctl;

    logic [CFG_W-1:0]   r_cfg;
    logic [NW-1:0]      w_len;
    logic [CW-1:0]      r_cnt;
    logic [IW-1:0]      w_idx;
    logic               w_head_act;
    logic [LEN_W-1:0]   r_need;
    logic [OWNER_W-1:0] r_harg;
    logic [OWNER_W-1:0] r_last;
    logic [NW-1:0]      r_run;
    logic [NW-1:0]      n_run;
    logic [IW-1:0]      r_start;
    logic               r_found, n_found;
    logic               r_hit, n_hit;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [OWNER_W-1:0]  r_res_handle, n_res_handle;
    logic               r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [OWNER_W-1:0]  r_o_handle;
    logic               w_accept, w_load, w_pass_end, w_pack_end;
    logic [OWNER_W-1:0] w_head, w_wr;
    logic [15:0]        w_fill_end;

    logic [OWNER_W-1:0] w_val  [CELLS];
    logic               w_free [CELLS];

    assign w_len = (int'(r_cfg) > CELLS) ? NW'(CELLS) : NW'(r_cfg);
    assign w_idx = r_cnt[IW-1:0];
    assign w_head_act = ({1'b0, w_idx} < w_len);
    assign w_head = w_val[0];
    assign w_pass_end = (r_cnt == PASS_END);
    assign w_pack_end = (r_cnt == PACK_END);
    assign w_fill_end = 16'(r_start) + 16'(r_need);

    genvar gi;
    generate
        for (gi = 0; gi < CELLS; gi++) begin : g_cell
            logic [OWNER_W-1:0] w_up;
            logic               w_low;
            if (gi == CELLS - 1) begin : g_last
                assign w_up = w_wr;
            end else begin : g_mid
                assign w_up = w_val[gi+1];
            end
            if (gi == 0) begin : g_first
                assign w_low = 1'b0;
            end else begin : g_rest
                assign w_low = w_free[gi-1];
            end
            ffca_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_active   (NW'(gi) < w_len),
                .i_top      (NW'(gi + 1) >= w_len),
                .i_low_free (w_low),
                .i_up       (w_up),
                .o_val      (w_val[gi]),
                .o_free     (w_free[gi])
            );
        end
    endgenerate

    always_comb begin
        n_run   = r_run;
        n_found = r_found;
        if (w_head_act && !r_found) begin
            if (w_head == '0) begin
                n_run = r_run + 1'b1;
                if (16'(r_run) + 16'd1 >= 16'(r_need)) begin
                    n_found = 1'b1;
                end
            end else begin
                n_run = '0;
            end
        end
    end

    assign n_hit = r_hit || (w_head_act && w_head == r_harg && r_harg != '0);

    always_comb begin
        w_wr = w_head;
        case (r_state)
            S_FILL: begin
                if (w_head_act && 16'(w_idx) >= 16'(r_start) && 16'(w_idx) < w_fill_end) begin
                    w_wr = r_last + 1'b1;
                end
            end
            S_ERASE: begin
                if (w_head_act && w_head == r_harg && r_harg != '0) begin
                    w_wr = '0;
                end
            end
            default: w_wr = w_head;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_ALLOC) begin
                        n_state = (i_block_length == '0 || r_last == HANDLE_MAX)
                                  ? S_DONE : S_SCAN;
                    end else if (i_op == OP_ERASE) begin
                        n_state = S_ERASE;
                    end else begin
                        n_state = S_PACK;
                    end
                end
            end
            S_SCAN:  if (w_pass_end) n_state = n_found ? S_FILL : S_DONE;
            S_FILL:  if (w_pass_end) n_state = S_DONE;
            S_ERASE: if (w_pass_end) n_state = S_DONE;
            S_PACK:  if (w_pack_end) n_state = S_DONE;
            S_DONE:  if (!r_o_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready      = 1'b0;
        w_ctl        = '0;
        w_load       = 1'b0;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        unique case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                n_res_status = ST_NULL;
                n_res_handle = '0;
            end
            S_SCAN: begin
                w_ctl.shift = 1'b1;
            end
            S_FILL: begin
                w_ctl.shift = 1'b1;
                if (w_pass_end) begin
                    n_res_status = ST_ALLOC;
                    n_res_handle = r_last + 1'b1;
                end
            end
            S_ERASE: begin
                w_ctl.shift = 1'b1;
                if (w_pass_end) begin
                    n_res_status = n_hit ? ST_ERASED : ST_ILLEGAL;
                end
            end
            S_PACK: begin
                w_ctl.pack = 1'b1;
                n_res_status = ST_DEFRAG;
            end
            S_DONE: begin
                w_load = !r_o_valid || i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign w_accept = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= CFG_RESET;
            r_cnt     <= '0;
            r_last    <= '0;
            r_o_valid <= 1'b0;
            r_run     <= '0;
            r_found   <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (w_accept || w_pack_end || (w_pass_end && r_state != S_PACK)) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_accept) begin
                r_run   <= '0;
                r_found <= 1'b0;
                r_hit   <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_run   <= n_run;
                r_found <= n_found;
            end else if (r_state == S_ERASE) begin
                r_hit <= n_hit;
            end
            if (r_state == S_FILL && w_pass_end) begin
                r_last <= r_last + 1'b1;
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_need <= i_block_length;
            r_harg <= i_handle_arg;
        end
        if (r_state == S_SCAN && w_head_act && !r_found && w_head == '0 && r_run == '0) begin
            r_start <= w_idx;
        end
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        if (w_load) begin
            r_o_status <= r_res_status;
            r_o_handle <= r_res_handle;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_handle_out = r_o_handle;

endmodule

[sv/ffca_cell.sv]
`timescale 1ns / 1ps
// One cell of the owner row: ring shift step and local compaction step.
module ffca_cell
    import ffca_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic               i_active,
    input  logic               i_top,
    input  logic               i_low_free,
    input  logic [OWNER_W-1:0] i_up,
    output logic [OWNER_W-1:0] o_val,
    output logic               o_free
);

    logic [OWNER_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_ctl.shift) begin
            r_val <= i_up;
        end else if (i_ctl.pack && i_active) begin
            if (r_val == '0) begin
                r_val <= i_top ? '0 : i_up;
            end else if (i_low_free) begin
                r_val <= '0;
            end
        end
    end

    assign o_val  = r_val;
    assign o_free = (r_val == '0);

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the first-fit cell allocator core.
module tb;
    import ffca_pkg::*;

    localparam int CELLS     = 128;
    localparam int N_RANDOM  = 930;
    localparam int CYC_LIMIT = 4000000;
    localparam logic [OP_W-1:0] OP_DEFRAG = 2'd2;
    localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [LEN_W-1:0]   len;
        logic [OWNER_W-1:0] handle;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OWNER_W-1:0]  handle;
    } t_rsp;

    typedef struct packed {
        t_req req;
        logic known;
        t_rsp rsp;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [OP_W-1:0]     i_op;
    logic [LEN_W-1:0]    i_block_length;
    logic [OWNER_W-1:0]  i_handle_arg;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [OWNER_W-1:0]  o_handle_out;
    logic                i_cfg_we;
    logic [CFG_W-1:0]    i_cfg_wdata;

    logic [OWNER_W-1:0] owner_mdl [CELLS];
    logic [OWNER_W-1:0] last_handle_mdl;
    logic [CFG_W-1:0]   row_cfg;

    t_rsp pending_rsp[$];
    t_row dir_rows[$];
    int   n_fail;
    int   n_checked;
    int   n_sent;
    int   n_alloc;
    int   n_null;
    int   n_erase;
    int   n_illegal;
    int   cycle = 0;
    bit   hold_rx;
    bit   stim_done;

    first_fit_cell_allocator_core #(.CELLS(CELLS)) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_block_length (i_block_length),
        .i_handle_arg   (i_handle_arg),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_handle_out   (o_handle_out),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_rsp allocator_predict(t_req r);
        int   n;
        int   run;
        int   start;
        t_rsp res;
        n = (row_cfg > CELLS) ? CELLS : row_cfg;
        res = '0;
        if (r.op == OP_ALLOC) begin
            res.status = ST_NULL;
            run = 0;
            start = 0;
            if (r.len != 0 && last_handle_mdl != HANDLE_MAX) begin
                for (int i = 0; i < n; i++) begin
                    if (owner_mdl[i] == '0) begin
                        if (run == 0) start = i;
                        run++;
                        if (run >= r.len) begin
                            last_handle_mdl = last_handle_mdl + 1'b1;
                            for (int k = 0; k < r.len; k++) owner_mdl[start + k] = last_handle_mdl;
                            res.status = ST_ALLOC;
                            res.handle = last_handle_mdl;
                            break;
                        end
                    end else begin
                        run = 0;
                    end
                end
            end
        end else if (r.op == OP_ERASE) begin
            res.status = ST_ILLEGAL;
            if (r.handle != '0) begin
                for (int i = 0; i < n; i++) begin
                    if (owner_mdl[i] == r.handle) begin
                        owner_mdl[i] = '0;
                        res.status = ST_ERASED;
                    end
                end
            end
        end else begin
            run = 0;
            for (int i = 0; i < n; i++) begin
                if (owner_mdl[i] != '0) begin
                    start = owner_mdl[i];
                    owner_mdl[i] = '0;
                    owner_mdl[run] = start[OWNER_W-1:0];
                    run++;
                end
            end
            res.status = ST_DEFRAG;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle);
        n_fail++;
    endtask

    task automatic send_word(t_req r, logic known, t_rsp want);
        t_rsp p;
        int   gap;
        gap = 1;
        if ($urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(2, 5);
        end
        repeat (gap) @(posedge i_clk);
        p = allocator_predict(r);
        if (known && p != want) report_mismatch("table row", p, want);
        case (p.status)
            ST_ALLOC:   n_alloc++;
            ST_NULL:    n_null++;
            ST_ERASED:  n_erase++;
            ST_ILLEGAL: n_illegal++;
            default: ;
        endcase
        pending_rsp.push_back(p);
        i_valid        <= 1'b1;
        i_op           <= r.op;
        i_block_length <= r.len;
        i_handle_arg   <= r.handle;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        i_valid <= 1'b0;
        n_sent++;
    endtask

    task automatic drain;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (2 * CELLS + 10) @(posedge i_clk);
    endtask

    task automatic write_rows(logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        row_cfg = v;
    endtask

    function automatic t_req rand_req(int max_len);
        t_req r;
        int   k;
        k = $urandom_range(0, 99);
        r.len    = LEN_W'($urandom_range(1, max_len));
        r.handle = OWNER_W'($urandom);
        if (k < 50) begin
            r.op = OP_ALLOC;
            if ($urandom_range(0, 30) == 0) r.len = LEN_W'($urandom);
        end else if (k < 85) begin
            r.op = OP_ERASE;
            if (last_handle_mdl != '0 && $urandom_range(0, 4) != 0)
                r.handle = OWNER_W'(last_handle_mdl - $urandom_range(0, 12));
        end else begin
            r.op = ($urandom_range(0, 3) == 0) ? OP_SPARE : OP_DEFRAG;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp w;
        cycle <= cycle + 1;
        if (cycle > CYC_LIMIT) begin
            $display("timeout at cycle %0d", cycle);
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected word status", o_status, 0);
            end else begin
                w = pending_rsp.pop_front();
                if (o_status !== w.status) report_mismatch("status", o_status, w.status);
                if (o_handle_out !== w.handle) report_mismatch("handle", o_handle_out, w.handle);
                n_checked++;
            end
        end
    end

    initial begin
        int gap;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!stim_done || pending_rsp.size() != 0) begin
            if (hold_rx) begin
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 3);
                repeat (gap - 1) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
            @(posedge i_clk);
        end
        i_ready <= 1'b1;
    end

    initial begin
        hold_rx = 1'b1;
        repeat (4000) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    initial begin
        t_req r;
        t_row row;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = OP_ALLOC;
        i_block_length = '0;
        i_handle_arg = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        n_fail = 0;
        stim_done = 1'b0;
        last_handle_mdl = '0;
        row_cfg = CFG_RESET;
        for (int i = 0; i < CELLS; i++) owner_mdl[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_rows = '{
            '{'{OP_ERASE, 8'd1, 16'd1}, 1'b1, '{ST_ILLEGAL, 16'd0}},
            '{'{OP_ALLOC, 8'd0, 16'd0}, 1'b1, '{ST_NULL, 16'd0}},
            '{'{OP_ALLOC, 8'd129, 16'd0}, 1'b1, '{ST_NULL, 16'd0}},
            '{'{OP_ALLOC, 8'd1, 16'd0}, 1'b1, '{ST_ALLOC, 16'd1}},
            '{'{OP_ALLOC, 8'd127, 16'd0}, 1'b1, '{ST_ALLOC, 16'd2}},
            '{'{OP_ALLOC, 8'd1, 16'd0}, 1'b1, '{ST_NULL, 16'd0}},
            '{'{OP_ERASE, 8'd255, 16'd0}, 1'b1, '{ST_ILLEGAL, 16'd0}},
            '{'{OP_ERASE, 8'd0, 16'hFFFF}, 1'b1, '{ST_ILLEGAL, 16'd0}},
            '{'{OP_ERASE, 8'd0, 16'd1}, 1'b1, '{ST_ERASED, 16'd0}},
            '{'{OP_DEFRAG, 8'd0, 16'd0}, 1'b1, '{ST_DEFRAG, 16'd0}},
            '{'{OP_ALLOC, 8'd1, 16'd0}, 1'b1, '{ST_ALLOC, 16'd3}},
            '{'{OP_ERASE, 8'd0, 16'd2}, 1'b1, '{ST_ERASED, 16'd0}},
            '{'{OP_ALLOC, 8'd128, 16'd0}, 1'b0, '0},
            '{'{OP_ALLOC, 8'd255, 16'hAAAA}, 1'b1, '{ST_NULL, 16'd0}},
            '{'{OP_SPARE, 8'd255, 16'h5555}, 1'b0, '0},
            '{'{OP_ALLOC, 8'd3, 16'd0}, 1'b0, '0},
            '{'{OP_DEFRAG, 8'd0, 16'd0}, 1'b1, '{ST_DEFRAG, 16'd0}}
        };
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_word(row.req, row.known, row.rsp);
        end
        drain();

        write_rows(8'd0);
        send_word('{OP_ALLOC, 8'd1, 16'd0}, 1'b1, '{ST_NULL, 16'd0});
        send_word('{OP_ERASE, 8'd0, 16'd3}, 1'b1, '{ST_ILLEGAL, 16'd0});
        send_word('{OP_DEFRAG, 8'd0, 16'd0}, 1'b1, '{ST_DEFRAG, 16'd0});
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_rows(8'd1);
                1: write_rows(8'd8);
                2: write_rows(8'd200);
                3: write_rows(8'd2);
                4: write_rows(8'd32);
                default: write_rows(8'd128);
            endcase
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                r = rand_req((row_cfg > 16) ? 16 : ((row_cfg == 0) ? 1 : row_cfg));
                if ($urandom_range(0, 40) == 0) r.len = LEN_W'($urandom_range(64, 255));
                send_word(r, 1'b0, '0);
            end
            drain();
        end

        for (int i = 0; i < 10; i++) begin
            r = rand_req(4);
            r.op = OP_ALLOC;
            send_word(r, 1'b0, '0);
        end

        stim_done = 1'b1;
        drain();
        $display("sent %0d requests, checked %0d responses", n_sent, n_checked);
        $display("alloc %0d, null %0d, erased %0d, illegal %0d", n_alloc, n_null, n_erase,
                 n_illegal);
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
sv/ffca_pkg.sv
sv/ffca_cell.sv
sv/first_fit_cell_allocator_core.sv
verif/tb.sv
